[hdl/lhs_pkg.sv]
// ----------------------------------------------------------------------------
// lhs_pkg
// Shared types and constants of the latency histogram statistics unit.
// ----------------------------------------------------------------------------
package lhs_pkg;

	localparam int LHS_NUM_BOUNDS = 8;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_RECORD_ENABLE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP_BOUND_INDEX = 1'b1;
	localparam logic [2:0]           TOP_BOUND_RESET     = 3'd7;

	// stream widths
	localparam int S_TDATA_W = 152;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 264;
	localparam int M_TUSER_W = 3;

	typedef enum logic [1:0] {
		CMD_REQUEST  = 2'd0,
		CMD_UPSTREAM = 2'd1,
		CMD_BOUND_WR = 2'd2,
		CMD_BIN_RD   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_REQ_RECORDED = 3'd0,
		ST_UP_RECORDED  = 3'd1,
		ST_UP_PARTIAL   = 3'd2,
		ST_DISABLED     = 3'd3,
		ST_BOUND_WR     = 3'd4,
		ST_BIN_RD       = 3'd5
	} status_t;

	typedef struct packed {
		logic [63:0] cnt;
		logic [63:0] sum;
		logic [63:0] sq;
	} totals_t;

	typedef struct packed {
		totals_t     tot;
		logic [63:0] bin;
	} stat_t;

	// update request from stage 3 into the statistics store
	typedef struct packed {
		logic        wr;
		logic [31:0] lat;
		logic [63:0] sq;
	} upd_t;

endpackage

[hdl/latency_histogram_stats_unit.sv]
// ----------------------------------------------------------------------------
// latency_histogram_stats_unit
// Request and upstream latency statistics with bounded-bucket histograms.
// ----------------------------------------------------------------------------
//  channel   dir   handshake          payload
//  s_*       in    tvalid / tready    tdata, tuser, tlast
//  m_*       out   tvalid / tready    tdata, tuser
//  cfg_*     in    cfg_we             cfg_index, cfg_data
//
//  One request per cycle sustained while m_tready holds; stages are latency
//  calc, then bound compare + square + memory read, then read-modify-write.
//  Rate is set by the bin/totals memory RMW in stage 3, which forwards the
//  previous write so back-to-back hits on one bin are handled.
//  Reset: bins and totals read as zero through per-entry valid bits, no
//  clearing pass; bounds are undefined until written.
//  Stalls: each stage holds while the next one is full and stalled; bubbles still fill.
// ----------------------------------------------------------------------------
module latency_histogram_stats_unit
	import lhs_pkg::*;
#(
	parameter int NUM_BOUNDS = LHS_NUM_BOUNDS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// now_sec, now_msec, from_sec, from_msec, response_ms, table_index,
	// bound_value
	input  logic [S_TDATA_W-1:0]  s_tdata,
	// cmd, histogram_select
	input  logic [S_TUSER_W-1:0]  s_tuser,
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// bucket, event_count, latency_total, latency_square_total, bin_count,
	// zero pad
	output logic [M_TDATA_W-1:0]  m_tdata,
	// status
	output logic [M_TUSER_W-1:0]  m_tuser
);

	localparam int BIN_W = $clog2(NUM_BOUNDS + 1);

	// configuration
	logic        enable_q;
	logic [2:0]  top_q;

	// handshake chain
	logic        v_s1, v_s2, v_s3, m_tvalid_q;
	logic        rdy_out, rdy1, rdy2, rdy3;
	logic        go1, go2, go3, acc_in;

	// stage 1
	cmd_t        cmd_s1;
	logic [31:0] now_sec_s1, from_sec_s1, resp_s1, bound_s1;
	logic [9:0]  now_msec_s1, from_msec_s1;
	logic        last_s1, hsel_s1;
	logic [3:0]  idx_s1;
	logic [31:0] elapsed1, acc_q, acc_sat1, lat1;
	logic [32:0] acc_sum1;
	status_t     st1;
	logic        hist1;

	// stage 2
	status_t     st_s2;
	logic [31:0] lat_s2;
	logic        hist_s2;
	logic [3:0]  idx_s2;
	logic [BIN_W-1:0] pick2, bin2;
	logic        bin_ok2;
	logic [63:0] sq2;

	// stage 3
	status_t     st_s3;
	logic [31:0] lat_s3;
	logic [3:0]  idx_s3;
	logic [BIN_W-1:0] bin_s3;
	logic        bin_ok_s3;
	logic [63:0] sq_s3;
	upd_t        upd3;
	stat_t       cur3, nxt3;

	// output register
	status_t     st_o_q;
	logic [3:0]  bucket_o_q;
	stat_t       stat_o_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			top_q    <= TOP_BOUND_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RECORD_ENABLE:   enable_q <= cfg_data[0];
				CFG_TOP_BOUND_INDEX: top_q    <= cfg_data[2:0];
				default:             ;
			endcase
		end
	end

	assign rdy_out  = !m_tvalid_q || m_tready;
	assign rdy3     = !v_s3 || rdy_out;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign go3      = v_s3 && rdy_out;
	assign go2      = v_s2 && rdy3;
	assign go1      = v_s1 && rdy2;
	assign acc_in   = s_tvalid && rdy1;
	assign s_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (rdy1)    v_s1       <= s_tvalid;
			if (rdy2)    v_s2       <= v_s1;
			if (rdy3)    v_s3       <= v_s2;
			if (rdy_out) m_tvalid_q <= v_s3;
		end
	end

	// ---------------- stage 1: elapsed time, upstream sum, status
	always_ff @(posedge clk) begin
		if (acc_in) begin
			cmd_s1        <= cmd_t'(s_tuser[1:0]);
			hsel_s1       <= s_tuser[2];
			last_s1       <= s_tlast;
			now_sec_s1    <= s_tdata[31:0];
			now_msec_s1   <= s_tdata[41:32];
			from_sec_s1   <= s_tdata[73:42];
			from_msec_s1  <= s_tdata[83:74];
			resp_s1       <= s_tdata[115:84];
			idx_s1        <= s_tdata[119:116];
			bound_s1      <= s_tdata[151:120];
		end
	end

	lhs_elapsed u_elapsed (
		.now_sec    (now_sec_s1),
		.now_msec   (now_msec_s1),
		.from_sec   (from_sec_s1),
		.from_msec  (from_msec_s1),
		.lat        (elapsed1)
	);

	assign acc_sum1 = {1'b0, acc_q} + {1'b0, resp_s1};
	assign acc_sat1 = acc_sum1[32] ? 32'hFFFF_FFFF : acc_sum1[31:0];

	always_comb begin
		case (cmd_s1)
			CMD_REQUEST:  st1 = enable_q ? ST_REQ_RECORDED : ST_DISABLED;
			CMD_UPSTREAM: begin
				if (!enable_q) begin
					st1 = ST_DISABLED;
				end else begin
					st1 = last_s1 ? ST_UP_RECORDED : ST_UP_PARTIAL;
				end
			end
			CMD_BOUND_WR: st1 = ST_BOUND_WR;
			CMD_BIN_RD:   st1 = ST_BIN_RD;
			default:      st1 = ST_DISABLED;
		endcase
	end

	assign lat1  = (cmd_s1 == CMD_REQUEST) ? elapsed1 : acc_sat1;
	assign hist1 = (cmd_s1 == CMD_BIN_RD) ? hsel_s1 : (cmd_s1 == CMD_UPSTREAM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 32'd0;
		end else if (go1) begin
			if (st1 == ST_UP_RECORDED) begin
				acc_q <= 32'd0;
			end else if (st1 == ST_UP_PARTIAL) begin
				acc_q <= acc_sat1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go1) begin
			st_s2   <= st1;
			lat_s2  <= lat1;
			hist_s2 <= hist1;
			idx_s2  <= idx_s1;
		end
	end

	// ---------------- stage 2: bin select, square, memory read
	// bound writes land as the item leaves stage 1, ahead of later compares
	lhs_bound_table #(
		.NUM_BOUNDS (NUM_BOUNDS)
	) u_bounds (
		.clk     (clk),
		.wr_en   (go1 && cmd_s1 == CMD_BOUND_WR),
		.wr_idx  (idx_s1),
		.wr_data (bound_s1),
		.top_idx (top_q),
		.lat     (lat_s2),
		.bin     (pick2)
	);

	assign bin_ok2 = int'(idx_s2) < NUM_BOUNDS + 1;

	always_comb begin
		if (st_s2 == ST_BIN_RD) begin
			bin2 = bin_ok2 ? BIN_W'(idx_s2) : '0;
		end else begin
			bin2 = pick2;
		end
	end

	assign sq2 = {32'd0, lat_s2} * {32'd0, lat_s2};

	always_ff @(posedge clk) begin
		if (go2) begin
			st_s3     <= st_s2;
			lat_s3    <= lat_s2;
			idx_s3    <= idx_s2;
			bin_s3    <= bin2;
			bin_ok_s3 <= bin_ok2;
			sq_s3     <= sq2;
		end
	end

	// ---------------- stage 3: read-modify-write of bin and totals
	assign upd3.wr  = go3 && (st_s3 == ST_REQ_RECORDED || st_s3 == ST_UP_RECORDED);
	assign upd3.lat = lat_s3;
	assign upd3.sq  = sq_s3;

	lhs_stat_mem #(
		.NUM_BOUNDS (NUM_BOUNDS)
	) u_stats (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (go2),
		.rd_hist (hist_s2),
		.rd_bin  (bin2),
		.upd     (upd3),
		.cur     (cur3),
		.nxt     (nxt3)
	);

	always_ff @(posedge clk) begin
		if (go3) begin
			st_o_q <= st_s3;
			case (st_s3)
				ST_REQ_RECORDED, ST_UP_RECORDED: begin
					bucket_o_q <= 4'(bin_s3);
					stat_o_q   <= nxt3;
				end
				ST_BOUND_WR: begin
					bucket_o_q <= idx_s3;
					stat_o_q   <= '0;
				end
				ST_BIN_RD: begin
					bucket_o_q   <= idx_s3;
					stat_o_q.tot <= cur3.tot;
					stat_o_q.bin <= bin_ok_s3 ? cur3.bin : 64'd0;
				end
				default: begin
					bucket_o_q <= 4'd0;
					stat_o_q   <= '0;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = st_o_q;
	assign m_tdata  = {4'd0, stat_o_q.bin, stat_o_q.tot.sq, stat_o_q.tot.sum,
		stat_o_q.tot.cnt, bucket_o_q};

endmodule

[hdl/lhs_elapsed.sv]
// ----------------------------------------------------------------------------
// lhs_elapsed
// Elapsed milliseconds between two timestamps, clamped at 0 and 32-bit max.
// ----------------------------------------------------------------------------
module lhs_elapsed
	import lhs_pkg::*;
(
	input  logic [31:0] now_sec,
	input  logic [9:0]  now_msec,
	input  logic [31:0] from_sec,
	input  logic [9:0]  from_msec,
	output logic [31:0] lat
);

	logic signed [32:0] dsec;
	logic signed [43:0] dsec_x;
	logic signed [43:0] ms;
	logic signed [10:0] dms;
	logic signed [43:0] e;

	assign dsec   = $signed({1'b0, now_sec}) - $signed({1'b0, from_sec});
	assign dsec_x = {{11{dsec[32]}}, dsec};
	// x * 1000 = x * 1024 - x * 16 - x * 8
	assign ms     = (dsec_x <<< 10) - (dsec_x <<< 4) - (dsec_x <<< 3);
	assign dms    = $signed({1'b0, now_msec}) - $signed({1'b0, from_msec});
	assign e      = ms + {{33{dms[10]}}, dms};

	always_comb begin
		if (e[43]) begin
			lat = 32'd0;
		end else if (|e[42:32]) begin
			lat = 32'hFFFF_FFFF;
		end else begin
			lat = e[31:0];
		end
	end

endmodule

[hdl/lhs_bound_table.sv]
// ----------------------------------------------------------------------------
// lhs_bound_table
// Bucket bound storage and parallel compare picking the histogram bin.
// ----------------------------------------------------------------------------
module lhs_bound_table
	import lhs_pkg::*;
#(
	parameter int NUM_BOUNDS = LHS_NUM_BOUNDS
) (
	input  logic                               clk,
	input  logic                               wr_en,
	input  logic [3:0]                         wr_idx,
	input  logic [31:0]                        wr_data,
	input  logic [2:0]                         top_idx,
	input  logic [31:0]                        lat,
	output logic [$clog2(NUM_BOUNDS + 1)-1:0]  bin
);

	localparam int BIN_W = $clog2(NUM_BOUNDS + 1);
	localparam int IDX_W = (NUM_BOUNDS > 1) ? $clog2(NUM_BOUNDS) : 1;

	logic [31:0]      bound_q [NUM_BOUNDS];
	logic             wr_ok;
	logic [BIN_W-1:0] top_eff;

	assign wr_ok = int'(wr_idx) < NUM_BOUNDS;

	always_ff @(posedge clk) begin
		if (wr_en && wr_ok) begin
			bound_q[IDX_W'(wr_idx)] <= wr_data;
		end
	end

	always_comb begin
		if (int'(top_idx) > NUM_BOUNDS - 1) begin
			top_eff = BIN_W'(NUM_BOUNDS - 1);
		end else begin
			top_eff = BIN_W'(top_idx);
		end
	end

	// first bound in use above the latency wins; none means overflow bin
	always_comb begin
		bin = BIN_W'(int'(top_eff) + 1);
		for (int i = NUM_BOUNDS - 1; i >= 0; i--) begin
			if (i <= int'(top_eff) && lat < bound_q[i]) begin
				bin = BIN_W'(i);
			end
		end
	end

endmodule

[hdl/lhs_stat_mem.sv]
// ----------------------------------------------------------------------------
// lhs_stat_mem
// Bin and totals memories with read-modify-write and write forwarding.
// ----------------------------------------------------------------------------
module lhs_stat_mem
	import lhs_pkg::*;
#(
	parameter int NUM_BOUNDS = LHS_NUM_BOUNDS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               rd_en,
	input  logic                               rd_hist,
	input  logic [$clog2(NUM_BOUNDS + 1)-1:0]  rd_bin,
	input  upd_t                               upd,
	output stat_t                              cur,
	output stat_t                              nxt
);

	localparam int BIN_W  = $clog2(NUM_BOUNDS + 1);
	localparam int ADDR_W = BIN_W + 1;
	localparam int DEPTH  = 2 ** ADDR_W;

	logic [63:0]       bin_mem_q [DEPTH];
	totals_t           tot_mem_q [2];
	logic [DEPTH-1:0]  bin_vld_q;
	logic [1:0]        tot_vld_q;

	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] addr_q;
	logic [63:0]       bin_rd_q;
	totals_t           tot_rd_q;
	logic              bin_rd_vld_q;
	logic              tot_rd_vld_q;

	logic              wb_vld_q;
	logic [ADDR_W-1:0] wb_addr_q;
	logic [63:0]       wb_bin_q;
	totals_t           wb_tot_q;

	logic              hist_q;

	assign rd_addr = {rd_hist, rd_bin};
	assign hist_q  = addr_q[ADDR_W-1];

	always_ff @(posedge clk) begin
		if (rd_en) begin
			bin_rd_q <= bin_mem_q[rd_addr];
			tot_rd_q <= tot_mem_q[rd_hist];
		end
	end

	always_ff @(posedge clk) begin
		if (upd.wr) begin
			bin_mem_q[addr_q] <= nxt.bin;
			tot_mem_q[hist_q] <= nxt.tot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_vld_q    <= '0;
			tot_vld_q    <= '0;
			bin_rd_vld_q <= 1'b0;
			tot_rd_vld_q <= 1'b0;
			addr_q       <= '0;
			wb_vld_q     <= 1'b0;
		end else begin
			if (rd_en) begin
				bin_rd_vld_q <= bin_vld_q[rd_addr];
				tot_rd_vld_q <= tot_vld_q[rd_hist];
				addr_q       <= rd_addr;
			end
			if (upd.wr) begin
				bin_vld_q[addr_q] <= 1'b1;
				tot_vld_q[hist_q] <= 1'b1;
				wb_vld_q          <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.wr) begin
			wb_addr_q <= addr_q;
			wb_bin_q  <= nxt.bin;
			wb_tot_q  <= nxt.tot;
		end
	end

	// last write may have landed in the same edge as this read
	always_comb begin
		if (wb_vld_q && wb_addr_q[ADDR_W-1] == hist_q) begin
			cur.tot = wb_tot_q;
		end else if (tot_rd_vld_q) begin
			cur.tot = tot_rd_q;
		end else begin
			cur.tot = '0;
		end
		if (wb_vld_q && wb_addr_q == addr_q) begin
			cur.bin = wb_bin_q;
		end else if (bin_rd_vld_q) begin
			cur.bin = bin_rd_q;
		end else begin
			cur.bin = '0;
		end
	end

	assign nxt.tot.cnt = cur.tot.cnt + 64'd1;
	assign nxt.tot.sum = cur.tot.sum + {32'd0, upd.lat};
	assign nxt.tot.sq  = cur.tot.sq + upd.sq;
	assign nxt.bin     = cur.bin + 64'd1;

endmodule

[hdl/lhs_checker.sv]
// ----------------------------------------------------------------------------
// lhs_checker
// Port-level checks on the result stream of the statistics unit.
// ----------------------------------------------------------------------------
module lhs_checker
	import lhs_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [M_TUSER_W-1:0] m_tuser
);

	// a held result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// partial and disabled results carry no statistics
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_UP_PARTIAL || m_tuser == ST_DISABLED)
		|-> m_tdata == '0)
		else $error("nonzero payload on partial or disabled result");

	// bound write echoes only the index
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_BOUND_WR |-> m_tdata[M_TDATA_W-1:4] == '0)
		else $error("bound write result carries statistics");

	// a recorded event has bumped both its count and its bin
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_REQ_RECORDED || m_tuser == ST_UP_RECORDED)
		|-> m_tdata[67:4] != 64'd0 && m_tdata[259:196] != 64'd0)
		else $error("recorded event with zero count or bin");

endmodule

bind latency_histogram_stats_unit lhs_checker u_lhs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

[verif/latency_histogram_stats_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// latency_histogram_stats_unit_test
// Drives request, upstream, bound write and bin read commands with random
// stalls on both streams, and keeps its own copy of the counters, sums and
// histogram bins to check every response field by field.
// ----------------------------------------------------------------------------
module latency_histogram_stats_unit_test
	import lhs_pkg::*;
;

	localparam int NB       = LHS_NUM_BOUNDS;
	localparam int NBINS    = NB + 1;
	localparam int MAX_CYC  = 300000;

	typedef struct {
		cmd_t        cmd;
		logic [31:0] now_sec;
		logic [9:0]  now_msec;
		logic [31:0] from_sec;
		logic [9:0]  from_msec;
		logic [31:0] response_ms;
		logic        is_last;
		logic [3:0]  table_index;
		logic        hist_sel;
		logic [31:0] bound_value;
	} stat_cmd_t;

	typedef struct packed {
		status_t     status;
		logic [3:0]  bucket;
		totals_t     tot;
		logic [63:0] bin;
	} stat_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic [S_TUSER_W-1:0]  s_tuser = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [M_TUSER_W-1:0]  m_tuser;

	latency_histogram_stats_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// shadow of the block state; index 0 request histogram, 1 upstream
	logic [31:0]  bound_shadow [NB];
	logic [63:0]  bins_shadow [2][NBINS];
	totals_t      totals_shadow [2];
	logic [31:0]  upstream_acc;
	logic         rec_en = 1'b0;
	logic [2:0]   top_idx = TOP_BOUND_RESET;

	stat_cmd_t    stat_cmds_q [$];
	stat_result_t stat_results_q [$];
	stat_cmd_t    drv_item;
	logic         src_took = 1'b0;
	bit           calm = 1'b0;
	int           src_gap = 0;
	int           snk_gap = 0;
	int           err_cnt = 0;
	int           cycle_cnt = 0;
	longint       gen_span = 1000;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		for (int h = 0; h < 2; h++) begin
			totals_shadow[h] = '0;
			for (int b = 0; b < NBINS; b++)
				bins_shadow[h][b] = '0;
		end
		for (int b = 0; b < NB; b++)
			bound_shadow[b] = '0;
		upstream_acc = '0;
	end

	function automatic stat_result_t tally(int h, logic [31:0] lat);
		stat_result_t r;
		int b;
		r = '0;
		b = int'(top_idx) + 1;
		for (int i = int'(top_idx); i >= 0; i--)
			if (lat < bound_shadow[i])
				b = i;
		totals_shadow[h].cnt += 64'd1;
		totals_shadow[h].sum += {32'd0, lat};
		totals_shadow[h].sq  += {32'd0, lat} * {32'd0, lat};
		bins_shadow[h][b] += 64'd1;
		r.bucket = 4'(b);
		r.tot    = totals_shadow[h];
		r.bin    = bins_shadow[h][b];
		return r;
	endfunction

	function automatic stat_result_t predict_stats(stat_cmd_t it);
		stat_result_t r;
		longint ns, nm, ss, sm, e;
		logic [32:0] acc_sum;
		logic [31:0] acc_sat;
		int h;
		r = '0;
		if ((it.cmd == CMD_REQUEST || it.cmd == CMD_UPSTREAM) && !rec_en) begin
			r.status = ST_DISABLED;
			return r;
		end
		case (it.cmd)
			CMD_REQUEST: begin
				ns = it.now_sec;
				nm = it.now_msec;
				ss = it.from_sec;
				sm = it.from_msec;
				e = (ns - ss) * 1000 + nm - sm;
				if (e < 0)
					e = 0;
				if (e > 64'sh0FFFFFFFF)
					e = 64'sh0FFFFFFFF;
				r = tally(0, e[31:0]);
				r.status = ST_REQ_RECORDED;
			end
			CMD_UPSTREAM: begin
				acc_sum = {1'b0, upstream_acc} + {1'b0, it.response_ms};
				acc_sat = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
				if (it.is_last) begin
					upstream_acc = '0;
					r = tally(1, acc_sat);
					r.status = ST_UP_RECORDED;
				end else begin
					upstream_acc = acc_sat;
					r.status = ST_UP_PARTIAL;
				end
			end
			CMD_BOUND_WR: begin
				if (it.table_index < NB)
					bound_shadow[it.table_index] = it.bound_value;
				r.status = ST_BOUND_WR;
				r.bucket = it.table_index;
			end
			default: begin
				h = it.hist_sel;
				r.status = ST_BIN_RD;
				r.bucket = it.table_index;
				r.tot    = totals_shadow[h];
				if (it.table_index < NBINS)
					r.bin = bins_shadow[h][it.table_index];
			end
		endcase
		return r;
	endfunction

	// ---------------- stimulus builders ----------------
	function automatic stat_cmd_t blank_cmd(cmd_t c);
		stat_cmd_t it;
		it.cmd         = c;
		it.now_sec     = $urandom;
		it.now_msec    = 10'($urandom_range(0, 999));
		it.from_sec    = $urandom;
		it.from_msec   = 10'($urandom_range(0, 999));
		it.response_ms = $urandom;
		it.is_last     = 1'($urandom);
		it.table_index = 4'($urandom);
		it.hist_sel    = 1'($urandom);
		it.bound_value = $urandom;
		return it;
	endfunction

	task automatic push_raw_request(logic [31:0] ns, logic [9:0] nm,
			logic [31:0] ss, logic [9:0] sm);
		stat_cmd_t it;
		it = blank_cmd(CMD_REQUEST);
		it.now_sec   = ns;
		it.now_msec  = nm;
		it.from_sec  = ss;
		it.from_msec = sm;
		stat_cmds_q.push_back(it);
	endtask

	// request whose elapsed time comes out as lat
	task automatic push_request(longint lat);
		longint ss, sm, t;
		ss = $urandom_range(0, 32'hF000_0000);
		sm = $urandom_range(0, 999);
		t  = sm + lat % 1000;
		push_raw_request(32'(ss + lat / 1000 + t / 1000), 10'(t % 1000),
			32'(ss), 10'(sm));
	endtask

	task automatic push_upstream(logic [31:0] resp, logic is_last);
		stat_cmd_t it;
		it = blank_cmd(CMD_UPSTREAM);
		it.response_ms = resp;
		it.is_last     = is_last;
		stat_cmds_q.push_back(it);
	endtask

	task automatic push_bound(logic [3:0] idx, logic [31:0] val);
		stat_cmd_t it;
		it = blank_cmd(CMD_BOUND_WR);
		it.table_index = idx;
		it.bound_value = val;
		stat_cmds_q.push_back(it);
	endtask

	task automatic push_read(logic [3:0] idx, logic sel);
		stat_cmd_t it;
		it = blank_cmd(CMD_BIN_RD);
		it.table_index = idx;
		it.hist_sel    = sel;
		stat_cmds_q.push_back(it);
	endtask

	// waits until every request has come back
	task automatic drain();
		while (stat_cmds_q.size() != 0 || s_tvalid || stat_results_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [2:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == CFG_RECORD_ENABLE)
			rec_en = val[0];
		else
			top_idx = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(int n_items);
		longint b;
		int n, len, pick;
		b = $urandom_range(1, 20);
		for (int i = 0; i < NB; i++) begin
			push_bound(4'(i), 32'(b));
			gen_span = b;
			b += $urandom_range(1, 40 << i);
		end
		n = NB;
		while (n < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				if ($urandom_range(0, 9) == 0) begin
					if ($urandom_range(0, 1) == 0)
						push_raw_request($urandom, 10'($urandom_range(0, 999)),
							$urandom, 10'($urandom_range(0, 999)));
					else begin
						b = $urandom;
						push_raw_request(32'(b), 10'($urandom_range(0, 999)),
							32'(b), 10'($urandom_range(0, 999)));
					end
				end else
					push_request($urandom_range(0, 32'(gen_span + gen_span / 4 + 5)));
				n++;
			end else if (pick < 75) begin
				len = $urandom_range(1, 4);
				for (int k = 0; k < len; k++) begin
					push_upstream(($urandom_range(0, 11) == 0) ? $urandom :
						$urandom_range(0, 32'(gen_span / 2 + 5)),
						(k == len - 1) ? ($urandom_range(0, 9) != 0) : 1'b0);
					n++;
				end
			end else if (pick < 85) begin
				push_bound(4'($urandom), ($urandom_range(0, 7) == 0) ? $urandom :
					$urandom_range(0, 32'(gen_span)));
				n++;
			end else begin
				push_read(4'($urandom), 1'($urandom));
				n++;
			end
		end
		drain();
	endtask

	// ---------------- driver ----------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || src_took) begin
				if (!calm && src_gap > 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (!calm && $urandom_range(0, 9) == 0) begin
					src_gap = $urandom_range(1, 14) - 1;
					s_tvalid <= 1'b0;
				end else if (stat_cmds_q.size() != 0) begin
					drv_item = stat_cmds_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {drv_item.bound_value, drv_item.table_index,
						drv_item.response_ms, drv_item.from_msec, drv_item.from_sec,
						drv_item.now_msec, drv_item.now_sec};
					s_tuser  <= {drv_item.hist_sel, drv_item.cmd};
					s_tlast  <= drv_item.is_last;
				end else
					s_tvalid <= 1'b0;
			end
			if (calm)
				m_tready <= 1'b1;
			else if (snk_gap > 0) begin
				snk_gap--;
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 9) == 0) begin
				snk_gap = $urandom_range(1, 14) - 1;
				m_tready <= 1'b0;
			end else
				m_tready <= 1'b1;
		end
	end

	// ---------------- monitor / checker ----------------
	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			err_cnt++;
		end
	endtask

	always @(posedge clk) begin
		stat_result_t want;
		src_took <= s_tvalid && s_tready;
		if (s_tvalid && s_tready)
			stat_results_q.push_back(predict_stats(drv_item));
		if (m_tvalid && m_tready) begin
			if (stat_results_q.size() == 0) begin
				$error("response with no request outstanding");
				err_cnt++;
			end else begin
				want = stat_results_q.pop_front();
				check_field("status", 64'(want.status), 64'(m_tuser));
				check_field("bucket", 64'(want.bucket), 64'(m_tdata[3:0]));
				check_field("event_count", want.tot.cnt, m_tdata[67:4]);
				check_field("latency_total", want.tot.sum, m_tdata[131:68]);
				check_field("latency_square_total", want.tot.sq, m_tdata[195:132]);
				check_field("bin_count", want.bin, m_tdata[259:196]);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > MAX_CYC) begin
			$display("simulation failed");
			$finish;
		end
	end

	// ---------------- test sequence ----------------
	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// recording is off after reset
		push_raw_request(32'd20, 10'd5, 32'd10, 10'd0);
		push_upstream(32'd50, 1'b0);
		push_read(4'd0, 1'b0);
		push_read(4'd8, 1'b1);
		push_bound(4'd0, 32'd10);
		push_bound(4'd1, 32'd100);
		push_bound(4'd2, 32'd1000);
		push_bound(4'd3, 32'd10000);
		push_bound(4'd4, 32'd100000);
		push_bound(4'd5, 32'd1000000);
		push_bound(4'd6, 32'd100000000);
		push_bound(4'd7, 32'hFFFF_FFFF);
		push_bound(4'd15, 32'hFFFF_FFFF);   // out of range, dropped
		push_read(4'd15, 1'b1);
		drain();
		write_reg(CFG_RECORD_ENABLE, 3'd1);
		write_reg(CFG_TOP_BOUND_INDEX, 3'd7);

		push_raw_request(32'd5, 10'd0, 32'd6, 10'd0);               // negative, clamps
		push_raw_request(32'hFFFF_FFFF, 10'd999, 32'd0, 10'd0);     // saturates
		push_raw_request(32'd77, 10'd500, 32'd77, 10'd500);         // zero
		push_raw_request(32'd10, 10'd0, 32'd9, 10'd999);            // msec borrow
		push_request(10);                                           // on a bound
		push_upstream(32'hFFFF_FFFF, 1'b0);
		push_upstream(32'd5, 1'b1);                                 // saturated sum
		push_upstream(32'd7, 1'b1);
		push_read(4'd8, 1'b0);
		push_read(4'd0, 1'b1);
		push_read(4'd9, 1'b0);                                      // past last bin
		drain();

		random_phase(300);
		write_reg(CFG_TOP_BOUND_INDEX, 3'd0);
		random_phase(150);
		write_reg(CFG_RECORD_ENABLE, 3'd0);
		write_reg(CFG_TOP_BOUND_INDEX, 3'd4);
		random_phase(80);
		write_reg(CFG_RECORD_ENABLE, 3'd1);
		write_reg(CFG_TOP_BOUND_INDEX, 3'd3);
		random_phase(200);
		write_reg(CFG_TOP_BOUND_INDEX, 3'd7);
		calm = 1'b1;
		random_phase(320);
		repeat (20) @(posedge clk);

		if (err_cnt == 0 && stat_results_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[sim.f]
hdl/lhs_pkg.sv
hdl/lhs_elapsed.sv
hdl/lhs_bound_table.sv
hdl/lhs_stat_mem.sv
hdl/latency_histogram_stats_unit.sv
hdl/lhs_checker.sv
verif/latency_histogram_stats_unit_test.sv
